>>> sv/ple_pkg.sv
// Package with shared types and constants for the positional list engine.
package ple_pkg;

  localparam int Capacity  = 16;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_PREPEND = 3'd1,
    MODE_INSERT  = 3'd2,
    MODE_DELETE  = 3'd3,
    MODE_UPDATE  = 3'd4,
    MODE_READ    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_UPD,
    S_READ,
    S_OUT
  } state_t;

endpackage

>>> sv/positional_list_engine.sv
// Top level of the positional list engine: list memory and its sequencer.
//
//  channel | signals                                   | direction
//  in      | valid, ready, mode, position, data_value  | into block
//  out     | out_valid, out_ready, out_value,          | out of block
//          | out_position, status, fill_count, last_of_run
//
// Entries live in one memory with a registered read port.
// Insert and delete move one entry per cycle after a first read; read all
// gives one beat per cycle while the output slot is free. No new item is
// accepted until the result beat of the last one has been taken.
// Reset clears the fill count; memory contents stay undefined until written.
// A stalled result beat holds the sequencer until it is taken.
module positional_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  mode,
  input  logic [4:0]  position,
  input  logic signed [31:0] data_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_value,
  output logic [3:0]  out_position,
  output logic [1:0]  status,
  output logic [4:0]  fill_count,
  output logic        last_of_run
);

  localparam int IW = ple_pkg::IdxW;
  localparam int CW = ple_pkg::CntW;
  localparam int DW = ple_pkg::DataWidth;

  logic [DW-1:0] mem [ple_pkg::Capacity];
  logic [DW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  ple_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;       // walking index
  logic [CW-1:0] tgt, tgt_next;       // position of the operation
  logic [DW-1:0] word, word_next;     // word to place
  logic          rd_pend, rd_pend_next;

  logic          ov, ov_next;
  logic [DW-1:0] ovalue, ovalue_next;
  logic [3:0]    opos, opos_next;
  logic [1:0]    ost, ost_next;
  logic          olast, olast_next;

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ple_pkg::S_IDLE;
      count   <= '0;
      ov      <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      ov      <= ov_next;
      rd_pend <= rd_pend_next;
    end
    ptr    <= ptr_next;
    tgt    <= tgt_next;
    word   <= word_next;
    ovalue <= ovalue_next;
    opos   <= opos_next;
    ost    <= ost_next;
    olast  <= olast_next;
  end

  assign out_valid    = ov;
  assign out_value    = ovalue;
  assign out_position = opos;
  assign status       = ost;
  assign fill_count   = 5'(count);
  assign last_of_run  = olast;
  assign ready        = (state == ple_pkg::S_IDLE) && !ov;

  logic          slot_free;
  logic [CW-1:0] in_pos;
  assign slot_free = !ov || out_ready;
  assign in_pos    = CW'(position);

  // Sequencer: next state, memory control and result beat.
  always_comb begin
    state_next   = state;
    count_next   = count;
    ptr_next     = ptr;
    tgt_next     = tgt;
    word_next    = word;
    rd_pend_next = 1'b0;
    ov_next      = ov && !out_ready;
    ovalue_next  = ovalue;
    opos_next    = opos;
    ost_next     = ost;
    olast_next   = olast;
    rd_addr      = ptr[IW-1:0];
    wr_en        = 1'b0;
    wr_addr      = ptr[IW-1:0];
    wr_data      = rd_data;

    unique case (state)
      ple_pkg::S_IDLE: begin
        if (valid && ready) begin
          word_next   = DW'(data_value);
          ovalue_next = '0;
          opos_next   = '0;
          olast_next  = 1'b1;
          ost_next    = ple_pkg::ST_OK;
          priority if (mode == ple_pkg::MODE_APPEND || mode == ple_pkg::MODE_PREPEND
                       || mode == ple_pkg::MODE_INSERT) begin
            tgt_next = (mode == ple_pkg::MODE_APPEND) ? count :
                       (mode == ple_pkg::MODE_PREPEND) ? '0 : in_pos;
            if (mode == ple_pkg::MODE_INSERT && in_pos > count) begin
              ost_next = ple_pkg::ST_BADPOS;
              ov_next  = 1'b1;
            end else if (count >= CW'(ple_pkg::Capacity)) begin
              ost_next = ple_pkg::ST_FULL;
              ov_next  = 1'b1;
            end else begin
              // Shift up from the tail: read ptr-1, write ptr.
              ptr_next     = count;
              rd_addr      = IW'(count - 1'b1);
              rd_pend_next = 1'b1;
              state_next   = ple_pkg::S_UP;
            end
          end else if (mode == ple_pkg::MODE_DELETE || mode == ple_pkg::MODE_UPDATE
                       || mode == ple_pkg::MODE_READ) begin
            if (count == '0) begin
              ost_next = ple_pkg::ST_EMPTY;
              ov_next  = 1'b1;
            end else if (mode != ple_pkg::MODE_READ && in_pos >= count) begin
              ost_next = ple_pkg::ST_BADPOS;
              ov_next  = 1'b1;
            end else begin
              ptr_next     = (mode == ple_pkg::MODE_READ) ? '0 : in_pos;
              tgt_next     = (mode == ple_pkg::MODE_READ) ? '0 : in_pos;
              rd_addr      = (mode == ple_pkg::MODE_READ) ? '0 : position[IW-1:0];
              rd_pend_next = 1'b1;
              state_next   = (mode == ple_pkg::MODE_DELETE) ? ple_pkg::S_DOWN :
                             (mode == ple_pkg::MODE_UPDATE) ? ple_pkg::S_UPD :
                                                              ple_pkg::S_READ;
            end
          end else begin
            ov_next = 1'b1;
          end
        end
      end
      ple_pkg::S_UP: begin
        // Copy entry ptr-1 into ptr, walking down to the target.
        if (ptr == tgt) begin
          wr_en       = 1'b1;
          wr_addr     = tgt[IW-1:0];
          wr_data     = word;
          count_next  = count + 1'b1;
          ovalue_next = word;
          ov_next     = 1'b1;
          state_next  = ple_pkg::S_OUT;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = ptr[IW-1:0];
          ptr_next     = ptr - 1'b1;
          rd_addr      = IW'(ptr - 2'd2);
          rd_pend_next = 1'b1;
        end
      end
      ple_pkg::S_DOWN: begin
        // First data is the removed word; then pull each next entry down.
        if (ptr == tgt && rd_pend) begin
          ovalue_next = rd_data;
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(ptr - 1'b1);
        end
        if (ptr + 1'b1 >= count) begin
          count_next = count - 1'b1;
          ov_next    = 1'b1;
          state_next = ple_pkg::S_OUT;
        end else begin
          ptr_next     = ptr + 1'b1;
          rd_addr      = IW'(ptr + 1'b1);
          rd_pend_next = 1'b1;
        end
      end
      ple_pkg::S_UPD: begin
        ovalue_next = rd_data;
        wr_en       = 1'b1;
        wr_addr     = tgt[IW-1:0];
        wr_data     = word;
        ov_next     = 1'b1;
        state_next  = ple_pkg::S_OUT;
      end
      ple_pkg::S_READ: begin
        // Issue one read beat per entry once the output slot frees.
        if (rd_pend) begin
          if (slot_free) begin
            ovalue_next = rd_data;
            opos_next   = 4'(ptr);
            olast_next  = (ptr + 1'b1 == count);
            ov_next     = 1'b1;
            if (ptr + 1'b1 == count) begin
              state_next = ple_pkg::S_OUT;
            end else begin
              ptr_next = ptr + 1'b1;
              rd_addr  = IW'(ptr + 1'b1);
              rd_pend_next = 1'b1;
            end
          end else begin
            rd_pend_next = 1'b1;
          end
        end
      end
      ple_pkg::S_OUT: begin
        if (!ov_next) begin
          state_next = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the positional list engine with a bursty driver and stalling sink.
`timescale 1ns / 1ps
module tb_top;

  // One operation on the list, as presented on the input channel.
  typedef struct {
    logic [2:0]         op;
    logic [4:0]         pos;
    logic signed [31:0] word;
  } list_op_t;

  // One result beat, as seen on the output channel.
  typedef struct {
    logic signed [31:0] word;
    logic [3:0]         pos;
    logic [1:0]         st;
    logic [4:0]         fill;
    logic               last;
  } list_beat_t;

  localparam int WatchdogLimit = 20000;

  logic clk;
  logic rst;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [4:0] position;
  logic signed [31:0] data_value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_value;
  logic [3:0] out_position;
  logic [1:0] status;
  logic [4:0] fill_count;
  logic last_of_run;

  positional_list_engine uut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .mode(mode),
    .position(position), .data_value(data_value), .out_valid(out_valid),
    .out_ready(out_ready), .out_value(out_value), .out_position(out_position),
    .status(status), .fill_count(fill_count), .last_of_run(last_of_run)
  );

  list_op_t   pending_ops[$];
  list_beat_t expected_beats[$];

  // Shadow copy of the list contents used for prediction.
  logic signed [31:0] shadow_list[ple_pkg::Capacity];
  int shadow_count;

  int mismatches;
  int beats_checked;
  int ops_sent;
  int idle_cycles;
  int gap_left;
  int burst_left;
  int hold_left;
  int hold_requests;
  bit stim_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected beat.
  task automatic push_beat(input logic signed [31:0] w, input int p,
                           input ple_pkg::status_t s, input bit l);
    list_beat_t b;
    b.word = w;
    b.pos  = p[3:0];
    b.st   = s;
    b.fill = shadow_count[4:0];
    b.last = l;
    expected_beats.push_back(b);
  endtask

  // Apply one accepted operation to the shadow list and queue its results.
  task automatic apply_list_op(input list_op_t o);
    int p;
    logic signed [31:0] old_word;
    p = int'(o.pos);
    case (o.op)
      ple_pkg::MODE_APPEND, ple_pkg::MODE_PREPEND, ple_pkg::MODE_INSERT: begin
        if (o.op == ple_pkg::MODE_APPEND) p = shadow_count;
        else if (o.op == ple_pkg::MODE_PREPEND) p = 0;
        if (p > shadow_count) push_beat(0, 0, ple_pkg::ST_BADPOS, 1);
        else if (shadow_count >= ple_pkg::Capacity) push_beat(0, 0, ple_pkg::ST_FULL, 1);
        else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[p] = o.word;
          shadow_count++;
          push_beat(o.word, 0, ple_pkg::ST_OK, 1);
        end
      end
      ple_pkg::MODE_DELETE, ple_pkg::MODE_UPDATE: begin
        if (shadow_count == 0) push_beat(0, 0, ple_pkg::ST_EMPTY, 1);
        else if (p >= shadow_count) push_beat(0, 0, ple_pkg::ST_BADPOS, 1);
        else begin
          old_word = shadow_list[p];
          if (o.op == ple_pkg::MODE_UPDATE) shadow_list[p] = o.word;
          else begin
            for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
            shadow_count--;
          end
          push_beat(old_word, 0, ple_pkg::ST_OK, 1);
        end
      end
      ple_pkg::MODE_READ: begin
        if (shadow_count == 0) push_beat(0, 0, ple_pkg::ST_EMPTY, 1);
        else for (int i = 0; i < shadow_count; i++)
          push_beat(shadow_list[i], i, ple_pkg::ST_OK, i + 1 == shadow_count);
      end
      default: push_beat(0, 0, ple_pkg::ST_OK, 1);
    endcase
  endtask

  function automatic list_op_t make_op(input logic [2:0] op, input logic [4:0] pos,
                                       input logic signed [31:0] word);
    list_op_t o;
    o.op = op;
    o.pos = pos;
    o.word = word;
    return o;
  endfunction

  // Random operation biased toward valid positions and a busy list.
  function automatic list_op_t random_op();
    list_op_t o;
    int r;
    r = $urandom_range(0, 99);
    o.word = $urandom;
    if (r < 30) o.op = ple_pkg::MODE_APPEND;
    else if (r < 40) o.op = ple_pkg::MODE_PREPEND;
    else if (r < 55) o.op = ple_pkg::MODE_INSERT;
    else if (r < 72) o.op = ple_pkg::MODE_DELETE;
    else if (r < 85) o.op = ple_pkg::MODE_UPDATE;
    else if (r < 95) o.op = ple_pkg::MODE_READ;
    else o.op = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) < 8) o.pos = 5'($urandom_range(0, 16));
    else o.pos = 5'($urandom_range(0, 31));
    return o;
  endfunction

  // Driver: bursts of offers separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (valid && ready) begin
        apply_list_op(make_op(mode, position, data_value));
        ops_sent <= ops_sent + 1;
      end
      if (!valid || ready) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          list_op_t o;
          o = pending_ops.pop_front();
          valid <= 1'b1;
          mode <= o.op;
          position <= o.pos;
          data_value <= o.word;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Sink stall pattern, with long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests > 0 && hold_left == 0) begin
      hold_left <= 300;
      hold_requests <= hold_requests - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: value %0d status %0d",
                                       out_value, status);
      end else begin
        list_beat_t e;
        e = expected_beats.pop_front();
        beats_checked++;
        if (out_value !== e.word || out_position !== e.pos || status !== e.st ||
            fill_count !== e.fill || last_of_run !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp val %0d pos %0d st %0d fill %0d last %0d, ",
                      "got %0d %0d %0d %0d %0d"},
                     e.word, e.pos, e.st, e.fill, e.last,
                     out_value, out_position, status, fill_count, last_of_run);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (!stim_done || expected_beats.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired with %0d beats outstanding", expected_beats.size());
        $display("positional_list_engine regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int tail_wait;
    clk = 1'b0;
    rst = 1'b1;
    valid = 1'b0;
    out_ready = 1'b0;
    mode = ple_pkg::MODE_APPEND;
    position = '0;
    data_value = '0;
    shadow_count = 0;
    mismatches = 0;
    beats_checked = 0;
    ops_sent = 0;
    idle_cycles = 0;
    hold_requests = 0;
    stim_done = 0;

    // Directed: empty-list errors, extremes, full list, bad positions, unused modes.
    pending_ops.push_back(make_op(ple_pkg::MODE_READ, 5'd0, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_DELETE, 5'd0, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_UPDATE, 5'd0, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_INSERT, 5'd1, 32'sd5));
    pending_ops.push_back(make_op(ple_pkg::MODE_APPEND, 5'd0, 32'sh7fffffff));
    pending_ops.push_back(make_op(ple_pkg::MODE_PREPEND, 5'd31, 32'sh80000000));
    pending_ops.push_back(make_op(ple_pkg::MODE_INSERT, 5'd2, -32'sd1));
    pending_ops.push_back(make_op(ple_pkg::MODE_UPDATE, 5'd3, 32'sd1));
    pending_ops.push_back(make_op(ple_pkg::MODE_DELETE, 5'd31, 32'sd1));
    pending_ops.push_back(make_op(3'd6, 5'd0, -32'sd1));
    pending_ops.push_back(make_op(3'd7, 5'd31, -32'sd1));
    for (int i = 0; i < 14; i++)
      pending_ops.push_back(make_op(ple_pkg::MODE_INSERT, 5'(i), $urandom));
    pending_ops.push_back(make_op(ple_pkg::MODE_APPEND, 5'd0, 32'sd1));
    pending_ops.push_back(make_op(ple_pkg::MODE_INSERT, 5'd16, 32'sd2));
    pending_ops.push_back(make_op(ple_pkg::MODE_READ, 5'd0, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_UPDATE, 5'd15, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_DELETE, 5'd16, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_DELETE, 5'd0, 32'sd0));
    pending_ops.push_back(make_op(ple_pkg::MODE_DELETE, 5'd14, 32'sd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Long sink hold-off while the directed set is offered.
    hold_requests = 1;

    for (int i = 0; i < 68; i++) pending_ops.push_back(random_op());

    wait (pending_ops.size() == 0 && !valid);
    stim_done = 1;
    wait (expected_beats.size() == 0);
    tail_wait = 0;
    while (tail_wait < 50) begin
      @(posedge clk);
      tail_wait++;
    end

    $display("ran %0d list operations, checked %0d result beats, %0d mismatches",
             ops_sent, beats_checked, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("positional_list_engine regression: pass");
    else
      $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule
